// ----- rtl/shift_add_fold_checksum16_core_macros.svh -----
// Assertion macros shared by the checksum core.
`ifndef SHIFT_ADD_FOLD_CHECKSUM16_CORE_MACROS_SVH
`define SHIFT_ADD_FOLD_CHECKSUM16_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SFC16_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SFC16_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sfc16_pkg.sv -----
// Types, constants and the fold function of the shift-add checksum core.
`default_nettype none

package sfc16_pkg;

   // The sum stays below 2^17 after a fold and grows by at most eight
   // doublings before the next one, so 26 bits always hold it.
   localparam int unsigned SumW      = 26;
   localparam int unsigned PosW      = 9;
   localparam int unsigned GroupW    = 3;
   localparam int unsigned ByteW     = 8;
   localparam int unsigned CsumW     = 16;
   localparam int unsigned SkipW     = 8;

   localparam logic [SkipW-1:0]  SkipReset  = 8'd14;
   localparam logic [PosW-1:0]   PosMax     = 9'd511;
   // Message offsets of the checksum field, counted as zero.
   localparam logic [PosW-1:0]   CsumFieldLo = 9'd8;
   localparam logic [PosW-1:0]   CsumFieldHi = 9'd9;

   typedef logic [SumW-1:0] sum_type;

   // One input beat as held in the input register.
   typedef struct packed {
      logic [ByteW-1:0] data_byte;
      logic             segment_end;
      logic             message_end;
   } sfc16_item_type;

   // Result handed from the accumulator to the output register.
   typedef struct packed {
      logic             emit;
      logic [CsumW-1:0] checksum;
   } sfc16_result_type;

   // 16-bit end-around fold.
   function automatic sum_type fold16(input sum_type s);
      logic [CsumW:0] folded;
      folded = {1'b0, s[CsumW-1:0]} + (CsumW + 1)'(s[SumW-1:CsumW]);
      return SumW'(folded);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/sfc16_req_if.sv -----
// Byte channel into the checksum core.
`default_nettype none

interface sfc16_req_if;
   import sfc16_pkg::*;

   logic             valid;
   logic             ready;
   logic [ByteW-1:0] data_byte;
   logic             segment_end;
   logic             message_end;

   modport source (output valid, data_byte, segment_end, message_end, input ready);
   modport sink   (input valid, data_byte, segment_end, message_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/sfc16_rsp_if.sv -----
// Checksum result channel out of the core.
`default_nettype none

interface sfc16_rsp_if;
   import sfc16_pkg::*;

   logic             valid;
   logic             ready;
   logic [CsumW-1:0] checksum;

   modport source (output valid, checksum, input ready);
   modport sink   (input valid, checksum, output ready);
endinterface

`default_nettype wire

// ----- rtl/sfc16_csr_if.sv -----
// Configuration write channel carrying the header skip length.
`default_nettype none

interface sfc16_csr_if;
   import sfc16_pkg::*;

   logic             valid;
   logic             ready;
   logic [SkipW-1:0] header_skip;

   modport source (output valid, header_skip, input ready);
   modport sink   (input valid, header_skip, output ready);
endinterface

`default_nettype wire

// ----- rtl/sfc16_in_stage.sv -----
// Input register that holds one byte beat until the accumulator takes it.
`default_nettype none

module sfc16_in_stage
   import sfc16_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   sfc16_req_if.sink       req_bus,
   input  wire logic       advance,
   output sfc16_item_type  item,
   output logic            item_valid
);

   logic           valid_ff, valid_in;
   sfc16_item_type item_ff, item_in;
   logic           load;

   // The register takes a new beat when empty or when it empties this cycle.
   assign req_bus.ready = !valid_ff || advance;
   assign load          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in            = 1'b1;
         item_in.data_byte   = req_bus.data_byte;
         item_in.segment_end = req_bus.segment_end;
         item_in.message_end = req_bus.message_end;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

`default_nettype wire

// ----- rtl/sfc16_accum.sv -----
// Running sum, group and position state, and the shift-add-fold update.
`default_nettype none

module sfc16_accum
   import sfc16_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   sfc16_csr_if.sink           csr_bus,
   input  wire logic           advance,
   input  wire sfc16_item_type item,
   output sfc16_result_type    result
);

   logic [SkipW-1:0]  skip_ff, skip_in;
   sum_type           sum_ff, sum_in;
   logic [GroupW-1:0] group_ff, group_in;
   logic [PosW-1:0]   pos_ff, pos_in;

   logic              counted;
   logic [PosW-1:0]   msg_pos;
   logic [ByteW-1:0]  byte_val;
   sum_type           sum_a, sum_b, sum_c;
   logic [GroupW-1:0] group_a;
   logic              seg;

   // The skip register accepts a write in any cycle.
   assign csr_bus.ready = 1'b1;

   always_comb begin
      skip_in = skip_ff;
      if (csr_bus.valid) begin
         skip_in = csr_bus.header_skip;
      end
   end

   // One beat: skip test, checksum field masking, doubling add, then folds.
   always_comb begin
      counted  = pos_ff >= {1'b0, skip_ff};
      msg_pos  = pos_ff - {1'b0, skip_ff};
      byte_val = ((msg_pos == CsumFieldLo) || (msg_pos == CsumFieldHi)) ?
                 '0 : item.data_byte;

      sum_a   = sum_ff;
      group_a = group_ff;
      if (counted) begin
         sum_a   = {sum_ff[SumW-2:0], 1'b0} + SumW'(byte_val);
         group_a = group_ff + 1'b1;
         if (group_a == '0) begin
            sum_a = fold16(sum_a);
         end
      end

      seg   = item.segment_end || item.message_end;
      sum_b = seg ? fold16(sum_a) : sum_a;
      sum_c = fold16(sum_b);

      result.emit     = advance && item.message_end;
      result.checksum = sum_c[CsumW-1:0];

      sum_in   = sum_ff;
      group_in = group_ff;
      pos_in   = pos_ff;
      if (advance) begin
         if (item.message_end) begin
            sum_in   = '0;
            group_in = '0;
            pos_in   = '0;
         end else begin
            sum_in   = sum_b;
            group_in = seg ? '0 : group_a;
            pos_in   = (pos_ff < PosMax) ? pos_ff + 1'b1 : pos_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff  <= SkipReset;
         sum_ff   <= '0;
         group_ff <= '0;
         pos_ff   <= '0;
      end else begin
         skip_ff  <= skip_in;
         sum_ff   <= sum_in;
         group_ff <= group_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sfc16_out_stage.sv -----
// Output register that holds a checksum beat until the consumer takes it.
`default_nettype none

module sfc16_out_stage
   import sfc16_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire sfc16_result_type result,
   output logic                  slot_free,
   sfc16_rsp_if.source           rsp_bus
);

   logic             valid_ff, valid_in;
   logic [CsumW-1:0] csum_ff, csum_in;

   // Free when empty or when the held beat leaves in this cycle.
   assign slot_free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      csum_in  = csum_ff;
      if (result.emit) begin
         valid_in = 1'b1;
         csum_in  = result.checksum;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      csum_ff <= csum_in;
   end

   assign rsp_bus.valid    = valid_ff;
   assign rsp_bus.checksum = csum_ff;

endmodule

`default_nettype wire

// ----- rtl/shift_add_fold_checksum16_core.sv -----
// Top level of the 16-bit shift-add-fold packet checksum core.
`default_nettype none

// Accepts one packet byte per clock and, on the last byte of a packet, returns
// the 16-bit folded checksum. A byte beat is taken into an input register, the
// running sum is updated from that register when the beat moves on, and the
// checksum lands in the output register at the same edge. The sustained rate
// is one byte per cycle, set by the combinational double, add and end-around
// fold on the sum register; it drops only while the output register holds an
// untaken checksum and another last byte is waiting. The header skip length
// may be written at any time the core is idle and takes effect from the next
// byte; reset sets it to 14. No clearing pass follows reset.
module shift_add_fold_checksum16_core
   import sfc16_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   sfc16_req_if.sink    req_bus,
   sfc16_rsp_if.source  rsp_bus,
   sfc16_csr_if.sink    csr_bus
);

   `include "shift_add_fold_checksum16_core_macros.svh"

   sfc16_item_type   item;
   logic             item_valid;
   logic             advance;
   logic             slot_free;
   sfc16_result_type result;

   // A held beat moves on unless it needs the output register and that is full.
   assign advance = item_valid && (!item.message_end || slot_free);

   sfc16_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .advance    (advance),
      .item       (item),
      .item_valid (item_valid)
   );

   sfc16_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   sfc16_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .slot_free (slot_free),
      .rsp_bus   (rsp_bus)
   );

   // A last byte that moves on always leaves a checksum beat behind.
   `SFC16_ASSERT_NEXT(a_last_byte_emits, clock, reset, advance && item.message_end, rsp_bus.valid, "last byte gave no checksum")

   // Without a last byte moving on, an empty output stays empty.
   `SFC16_ASSERT_NEXT(a_no_spurious_rsp, clock, reset, !rsp_bus.valid && !(advance && item.message_end), !rsp_bus.valid, "checksum beat without a last byte")

   // A stalled input beat is neither lost nor overwritten.
   `SFC16_ASSERT_NEXT(a_item_held, clock, reset, item_valid && !advance, item_valid && $stable(item), "stalled input beat changed")

endmodule

`default_nettype wire
